// ===== hw/rtl/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

  localparam int unsigned CAP_W  = 5;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_mem.sv =====
`default_nettype none

module bdq_mem
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_core.sv =====
`default_nettype none

module bdq_core
  import bdq_pkg::*;
#(
  parameter int unsigned IDX_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CAP_W-1:0]  cap_i,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OP_W-1:0]   in_operation_i,
  input  wire logic [BYTE_W-1:0] in_push_byte_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [BYTE_W-1:0] out_popped_byte_o,
  output logic                   out_done_res_o,
  output logic                   out_now_empty_o,
  output logic                   out_now_full_o,
  output logic      [CAP_W-1:0]  out_entries_held_o,
  // store port
  output logic                   mem_we_o,
  output logic      [IDX_W-1:0]  mem_waddr_o,
  output logic      [BYTE_W-1:0] mem_wdata_o,
  output logic                   mem_re_o,
  output logic      [IDX_W-1:0]  mem_raddr_o,
  input  wire logic [BYTE_W-1:0] mem_rdata_i
);

  localparam int unsigned WW = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

  function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] idx,
                                               logic [CAP_W-1:0] cap);
    logic [WW-1:0] nxt;
    nxt = WW'(idx) + WW'(1);
    return (nxt >= WW'(cap)) ? '0 : IDX_W'(nxt);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] idx,
                                                 logic [CAP_W-1:0] cap);
    logic [WW-1:0] prv;
    prv = (idx == '0) ? (WW'(cap) - WW'(1)) : (WW'(idx) - WW'(1));
    return IDX_W'(prv);
  endfunction

  state_e            state_q, state_d;
  op_e               op_q;
  logic [BYTE_W-1:0] byte_q;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [IDX_W-1:0]  back_q, back_d;
  logic [CAP_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] popped_q, popped_d;
  logic              done_q, done_d;

  logic in_accept, out_free, commit, is_push, push_ok, pop_ok;
  logic [IDX_W-1:0] waddr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_EXEC) && out_free;

  // read the slot a pop will need as the word comes in
  assign mem_re_o    = in_accept;
  assign mem_raddr_o = (op_e'(in_operation_i) == OP_POP_FRONT) ? front_q : back_q;

  assign is_push = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
  assign push_ok = is_push && (cnt_q < cap_i);
  assign pop_ok  = !is_push && (cnt_q != '0);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    cnt_d    = cnt_q;
    waddr    = '0;
    popped_d = '0;
    done_d   = 1'b0;
    if (push_ok) begin
      done_d = 1'b1;
      cnt_d  = cnt_q + CAP_W'(1);
      if (cnt_q == '0) begin
        front_d = '0;
        back_d  = '0;
      end else if (op_q == OP_PUSH_FRONT) begin
        front_d = step_down(front_q, cap_i);
        waddr   = front_d;
      end else begin
        back_d = step_up(back_q, cap_i);
        waddr  = back_d;
      end
    end else if (pop_ok) begin
      done_d   = 1'b1;
      popped_d = mem_rdata_i;
      cnt_d    = cnt_q - CAP_W'(1);
      if (cnt_q != CAP_W'(1)) begin
        if (op_q == OP_POP_FRONT) begin
          front_d = step_up(front_q, cap_i);
        end else begin
          back_d = step_down(back_q, cap_i);
        end
      end
    end
  end

  assign mem_we_o    = commit && push_ok;
  assign mem_waddr_o = waddr;
  assign mem_wdata_o = byte_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        front_q <= front_d;
        back_q  <= back_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_e'(in_operation_i);
      byte_q <= in_push_byte_i;
    end
    if (commit) begin
      popped_q <= popped_d;
      done_q   <= done_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_popped_byte_o  = popped_q;
  assign out_done_res_o     = done_q;
  assign out_entries_held_o = cnt_q;
  assign out_now_empty_o    = (cnt_q == '0);
  assign out_now_full_o     = (cnt_q >= cap_i);

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (cnt_q < cap_i))
    else $error("store written while deque full");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_EXEC))
    else $error("accepted word not executed next cycle");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed result not presented");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CAP_W'(1) ||
                cnt_q == $past(cnt_q) - CAP_W'(1)))
    else $error("count moved by more than one");

endmodule

`default_nettype wire

// ===== hw/rtl/byte_deque_ring_buffer.sv =====
// Byte deque over a circular single-port-write / single-port-read store.
// An accepted word and its slot read are registered, then the update and write
// back commit the result register once the output is free; intake stalls until
// the read-modify-write commits. A stalled result holds one more word, then stalls intake.
// Reset clears both indices and the count and sets capacity to 16; store
// contents are undefined until written.
`default_nettype none

module byte_deque_ring_buffer
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CAP_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OP_W-1:0]   in_operation_i,
  input  wire logic [BYTE_W-1:0] in_push_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [BYTE_W-1:0] out_popped_byte_o,
  output logic                   out_done_res_o,
  output logic                   out_now_empty_o,
  output logic                   out_now_full_o,
  output logic      [CAP_W-1:0]  out_entries_held_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0] cap_q;
  logic [CAP_W-1:0] cap_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // zero means one slot; saturate at the store depth
  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_eff = CAP_W'(DEPTH);
    end
  end

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  bdq_core #(
    .IDX_W (IDX_W)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cap_i              (cap_eff),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_operation_i     (in_operation_i),
    .in_push_byte_i     (in_push_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_popped_byte_o  (out_popped_byte_o),
    .out_done_res_o     (out_done_res_o),
    .out_now_empty_o    (out_now_empty_o),
    .out_now_full_o     (out_now_full_o),
    .out_entries_held_o (out_entries_held_o),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_re_o           (mem_re),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata)
  );

  bdq_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
